@@ hdl/cbc_pkg.sv @@
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

   // access kind
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // 8 KiB bus windows, selected by address[15:13]
   localparam logic [2:0] WIN_RAM_EN   = 3'b000;
   localparam logic [2:0] WIN_ROM_BANK = 3'b001;
   localparam logic [2:0] WIN_RAM_BANK = 3'b010;
   localparam logic [2:0] WIN_MODE     = 3'b011;
   localparam logic [2:0] WIN_RAM      = 3'b101;

   // configuration register indexes
   localparam logic CSR_ROM_SIZE = 1'b0;
   localparam logic CSR_RAM_SIZE = 1'b1;

   // external RAM size codes
   localparam logic [1:0] RAM_NONE = 2'd0;
   localparam logic [1:0] RAM_8K   = 2'd1;

   localparam logic [3:0] ENABLE_KEY = 4'hA;
   localparam logic [7:0] OPEN_BUS   = 8'hFF;

   localparam int ROM_ADDR_W = 19;
   localparam int RAM_IDX_W  = 15;

   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]            read_data;
      logic                  from_rom;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  rom_out_of_range;
      logic                  cart_hit;
   } rsp_type;

   // live control / configuration registers
   typedef struct packed {
      logic [2:0] rom_size_code;
      logic [1:0] ram_size_code;
      logic       ram_enable;
      logic [4:0] rom_bank;
      logic [1:0] ram_bank;
      logic       banking_mode;
   } regs_type;

   // decode of one request
   typedef struct packed {
      rsp_type              rsp;
      logic                 use_mem;
      logic                 mem_we;
      logic [RAM_IDX_W-1:0] mem_index;
      logic                 wr_ram_enable;
      logic                 wr_rom_bank;
      logic                 wr_ram_bank;
      logic                 wr_mode;
      logic                 ram_enable_val;
      logic [4:0]           rom_bank_val;
      logic [1:0]           ram_bank_val;
      logic                 mode_val;
   } map_type;

endpackage

@@ hdl/cbc_map.sv @@
// Address decode and bank mapping for one bus request.
module cbc_map #(
   parameter int RAM_BYTES     = 32768,
   parameter int ROM_BANK_BITS = 5
) (
   input  cbc_pkg::req_type  req,
   input  cbc_pkg::regs_type regs,
   output cbc_pkg::map_type  map
);

   localparam logic [4:0] BANK_MASK = 5'((1 << ROM_BANK_BITS) - 1);
   localparam logic [cbc_pkg::RAM_IDX_W-1:0] RAM_MASK =
      cbc_pkg::RAM_IDX_W'(RAM_BYTES - 1);

   logic [2:0]                        window;
   logic                              ram_ok;
   logic [1:0]                        bank;
   logic [cbc_pkg::RAM_IDX_W-1:0]     size_mask;
   logic [cbc_pkg::ROM_ADDR_W-1:0]    rom_addr;
   logic [4:0]                        new_bank;
   logic                              oor;

   assign window   = req.address[15:13];
   assign ram_ok   = regs.ram_enable && (regs.ram_size_code != cbc_pkg::RAM_NONE);
   assign bank     = regs.banking_mode ? regs.ram_bank : 2'd0;
   assign size_mask = (regs.ram_size_code == cbc_pkg::RAM_8K) ? 15'h1FFF : 15'h7FFF;
   assign new_bank = req.write_data[4:0] & BANK_MASK;

   // lower 16 KiB fixed, upper 16 KiB through the bank register
   assign rom_addr = req.address[14] ? {regs.rom_bank, req.address[13:0]}
                                     : {5'd0, req.address[13:0]};

   always_comb begin
      case (regs.rom_size_code)
         3'd0:    oor = |rom_addr[18:15];
         3'd1:    oor = |rom_addr[18:16];
         3'd2:    oor = |rom_addr[18:17];
         3'd3:    oor = rom_addr[18];
         default: oor = 1'b0;
      endcase
   end

   always_comb begin
      map = '0;
      map.rsp.cart_hit = !req.address[15] || (window == cbc_pkg::WIN_RAM);
      map.mem_index    = {bank, req.address[12:0]} & size_mask & RAM_MASK;
      map.ram_enable_val = (req.write_data[3:0] == cbc_pkg::ENABLE_KEY);
      map.rom_bank_val   = (new_bank == 5'd0) ? 5'd1 : new_bank;
      map.ram_bank_val   = req.write_data[1:0];
      map.mode_val       = req.write_data[0];
      if (req.kind == cbc_pkg::KIND_WRITE) begin
         case (window)
            cbc_pkg::WIN_RAM_EN:   map.wr_ram_enable = 1'b1;
            cbc_pkg::WIN_ROM_BANK: map.wr_rom_bank   = 1'b1;
            cbc_pkg::WIN_RAM_BANK: map.wr_ram_bank   = 1'b1;
            cbc_pkg::WIN_MODE:     map.wr_mode       = 1'b1;
            cbc_pkg::WIN_RAM:      map.mem_we        = ram_ok;
            default:               map.mem_we        = 1'b0;
         endcase
      end else if (!req.address[15]) begin
         map.rsp.from_rom         = 1'b1;
         map.rsp.rom_address      = rom_addr;
         map.rsp.rom_out_of_range = oor;
      end else if ((window == cbc_pkg::WIN_RAM) && ram_ok) begin
         map.use_mem = 1'b1;
      end else begin
         map.rsp.read_data = cbc_pkg::OPEN_BUS;
      end
   end

endmodule

@@ hdl/cartridge_bank_controller.sv @@
// Top level of the cartridge bank controller: registers, RAM store, handshake.
// A request is accepted only in the idle state and held in the in-flight slot; it moves
//   to the output register once that register is free, and rsp_valid then holds until taken.
// A new request is taken only after the previous one has left the in-flight slot; the
//   synchronous RAM read and the single in-flight slot account for this.
// Reset: synchronous; afterwards a clearing pass zeroes the RAM store, one byte
//   per cycle, with req_stall high. CSR writes still land.
module cartridge_bank_controller #(
   parameter int RAM_BYTES     = 32768,
   parameter int ROM_BANK_BITS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cbc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cbc_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [2:0]        csr_wr_data
);

   localparam int RAM_AW = $clog2(RAM_BYTES);

   // one-hot sequencer: clearing pass, waiting for a request, request in flight
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_BUSY  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [RAM_AW-1:0]      clr_ff, clr_in;
   cbc_pkg::regs_type      regs_ff, regs_in;
   cbc_pkg::map_type       map;
   cbc_pkg::rsp_type       stage_ff, stage_in;
   logic                   use_mem_ff, use_mem_in;
   logic [7:0]             mem_q_ff;
   cbc_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   drain;
   logic                   mem_we;
   logic [RAM_AW-1:0]      mem_wa;
   logic [7:0]             mem_wd;
   logic [RAM_AW-1:0]      mem_ra;

   // RAM store: one write port, one registered read port
   logic [7:0] ram_mem [0:(2**RAM_AW)-1];

   cbc_map #(
      .RAM_BYTES     (RAM_BYTES),
      .ROM_BANK_BITS (ROM_BANK_BITS)
   ) u_map (
      .req  (req_data),
      .regs (regs_ff),
      .map  (map)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // in-flight request moves to the output register once it is free
   assign drain     = (state_ff == ST_BUSY) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (drain) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // control registers: bus writes to the control windows, CSR writes for sizes
   always_comb begin
      regs_in = regs_ff;
      if (accept) begin
         if (map.wr_ram_enable) regs_in.ram_enable   = map.ram_enable_val;
         if (map.wr_rom_bank)   regs_in.rom_bank     = map.rom_bank_val;
         if (map.wr_ram_bank)   regs_in.ram_bank     = map.ram_bank_val;
         if (map.wr_mode)       regs_in.banking_mode = map.mode_val;
      end
      if (csr_wr_en) begin
         case (csr_index)
            cbc_pkg::CSR_ROM_SIZE: regs_in.rom_size_code = csr_wr_data;
            cbc_pkg::CSR_RAM_SIZE: regs_in.ram_size_code = csr_wr_data[1:0];
            default:               regs_in = regs_ff;
         endcase
      end
   end

   // decoded response waits here while the RAM read completes
   assign stage_in   = accept ? map.rsp : stage_ff;
   assign use_mem_in = accept ? map.use_mem : use_mem_ff;

   // RAM ports: clearing pass owns the write port until done
   assign mem_we = (state_ff == ST_CLEAR) || (accept && map.mem_we);
   assign mem_wa = (state_ff == ST_CLEAR) ? clr_ff : map.mem_index[RAM_AW-1:0];
   assign mem_wd = (state_ff == ST_CLEAR) ? 8'd0 : req_data.write_data;
   assign mem_ra = map.mem_index[RAM_AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ram_mem[mem_wa] <= mem_wd;
      end
      // read only on accept, so the data holds while the response waits
      if (accept && map.use_mem) begin
         mem_q_ff <= ram_mem[mem_ra];
      end
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (drain) begin
         rsp_in = stage_ff;
         if (use_mem_ff) rsp_in.read_data = mem_q_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         regs_ff      <= '{rom_size_code: 3'd0, ram_size_code: 2'd0, ram_enable: 1'b0,
                           rom_bank: 5'd1, ram_bank: 2'd0, banking_mode: 1'b0};
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff   <= stage_in;
      use_mem_ff <= use_mem_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/cbc_checker.sv @@
// Port-level checks for the cartridge bank controller, bound to the top level.
module cbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cbc_pkg::rsp_type rsp_data
);

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // one request in flight: the port closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while one is in flight");

   // ROM responses hit the cartridge and carry no RAM byte
   a_rom_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.from_rom |-> rsp_data.cart_hit && (rsp_data.read_data == 8'd0))
      else $error("malformed ROM response");

   // range flag only on ROM reads
   a_oor_rom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rom_out_of_range |-> rsp_data.from_rom)
      else $error("out-of-range flag on a non-ROM response");

   // reset empties the output and starts the clearing pass
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("reset did not clear the response or stall requests");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
